// ===== hdl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== hdl/rdb_pkg.sv =====
// shared types, codes and helpers for the rrip dead block replacement block
// no dependencies
package rdb_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_RED, ST_DRD, ST_DWR, ST_RD, ST_EX
  } state_t;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [2:0] RSN_INVALID      = 3'd0;
  localparam logic [2:0] RSN_STREAM_RRPV3 = 3'd1;
  localparam logic [2:0] RSN_STREAM_RAND  = 3'd2;
  localparam logic [2:0] RSN_DEAD         = 3'd3;
  localparam logic [2:0] RSN_RRIP         = 3'd4;
  localparam logic [2:0] RSN_UPDATE       = 3'd5;

  localparam logic [1:0] CFG_DECAY_PERIOD = 2'd0;
  localparam logic [1:0] CFG_STREAM_STRIDE = 2'd1;
  localparam logic [1:0] CFG_BIMODAL_LOG2 = 2'd2;

  localparam logic [1:0] KIND_SRRIP    = 2'd0;
  localparam logic [1:0] KIND_BRRIP    = 2'd1;
  localparam logic [1:0] KIND_FOLLOWER = 2'd2;

  localparam logic [19:0] DECAY_PERIOD_RST = 20'd100000;
  localparam logic [15:0] STREAM_STRIDE_RST = 16'd64;
  localparam logic [3:0]  BIMODAL_LOG2_RST = 4'd5;

  localparam logic [15:0] LFSR_SEED = 16'h0001;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [1:0] RRPV_LONG = 2'd2;
  localparam logic [1:0] RRPV_NEAR = 2'd0;
  localparam logic [1:0] REUSE_RST = 2'd1;
  localparam logic [1:0] REUSE_HIT = 2'd3;
  localparam logic [1:0] CONF_MAX  = 2'd3;

  typedef struct packed {
    logic [15:0] prev_addr;
    logic [1:0]  conf;
    logic [1:0]  kind;
  } set_meta_t;

  // galois shift, right, taps on the low bit
  function automatic logic [15:0] lfsr_step(input logic [15:0] cur);
    logic [15:0] nxt;
    nxt = cur >> 1;
    if (cur[0]) begin
      nxt = nxt ^ LFSR_TAPS;
    end
    return nxt;
  endfunction

endpackage

// ===== hdl/rdb_row_mem.sv =====
// simple dual port row memory, one write and one registered read per cycle
// no dependencies
module rdb_row_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 84,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rdb_kernel.sv =====
// per-request row logic: victim search, aging, training and insertion
// depends on rdb_pkg
module rdb_kernel #(
  parameter int NUM_WAYS = 16,
  parameter int SELECTOR_BITS = 10,
  localparam int WAY_W = $clog2(NUM_WAYS),
  localparam int RV_W = NUM_WAYS * 2
) (
  input  logic                     op,
  input  logic [WAY_W-1:0]         way,
  input  logic [15:0]              valid_mask,
  input  logic [15:0]              addr_low,
  input  logic                     hit,
  input  logic [RV_W-1:0]          rrpv_in,
  input  logic [RV_W-1:0]          reuse_in,
  input  rdb_pkg::set_meta_t       meta_in,
  input  logic [SELECTOR_BITS-1:0] sel_in,
  input  logic [15:0]              stride,
  input  logic [3:0]               bim_log2,
  input  logic [15:0]              rnd,
  input  logic [WAY_W-1:0]         rnd_way,
  output logic [RV_W-1:0]          rrpv_out,
  output logic [RV_W-1:0]          reuse_out,
  output rdb_pkg::set_meta_t       meta_out,
  output logic [SELECTOR_BITS-1:0] sel_out,
  output logic [WAY_W-1:0]         vic_way,
  output logic [2:0]               reason,
  output logic                     rnd_used
);

  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
  localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
  localparam logic [1:0] RRPV_MAX_C = rdb_pkg::RRPV_MAX;

  logic [1:0] rr [NUM_WAYS];
  logic [1:0] ru [NUM_WAYS];
  logic [1:0] rr_new [NUM_WAYS];
  logic [1:0] ru_new [NUM_WAYS];
  logic [NUM_WAYS+15:0] mask_ext;
  logic [WAY_W-1:0] first_inv, first_r3, first_dead, first_mx;
  logic has_inv, has_r3, has_dead;
  logic [1:0] mx, age_add;
  logic [15:0] delta, bim_mask;
  logic streaming;
  logic [1:0] conf_n, trained, ins, bim;
  logic [SELECTOR_BITS-1:0] sel_n;

  always_comb begin
    mask_ext = (NUM_WAYS + 16)'(valid_mask);
    mx = 2'd0;
    has_inv = 1'b0;
    has_r3 = 1'b0;
    has_dead = 1'b0;
    first_inv = '0;
    first_r3 = '0;
    first_dead = '0;
    first_mx = '0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      rr[i] = rrpv_in[2*i +: 2];
      ru[i] = reuse_in[2*i +: 2];
      if (rr[i] > mx) begin
        mx = rr[i];
      end
    end
    // scan downward so the lowest matching way wins
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (!mask_ext[i]) begin
        has_inv = 1'b1;
        first_inv = WAY_W'(i);
      end
      if (rr[i] == RRPV_MAX_C) begin
        has_r3 = 1'b1;
        first_r3 = WAY_W'(i);
      end
      if (rr[i] == RRPV_MAX_C && ru[i] == 2'd0) begin
        has_dead = 1'b1;
        first_dead = WAY_W'(i);
      end
      if (rr[i] == mx) begin
        first_mx = WAY_W'(i);
      end
    end
    age_add = rdb_pkg::RRPV_MAX - mx;
  end

  always_comb begin
    delta = addr_low - meta_in.prev_addr;
    streaming = (delta == stride) || (delta == (16'd0 - stride));
    bim_mask = 16'((17'd1 << bim_log2) - 17'd1);
    bim = ((rnd & bim_mask) == 16'd0) ? rdb_pkg::RRPV_NEAR : rdb_pkg::RRPV_LONG;
    if (streaming) begin
      conf_n = (meta_in.conf == rdb_pkg::CONF_MAX) ? meta_in.conf : meta_in.conf + 2'd1;
    end else begin
      conf_n = (meta_in.conf == 2'd0) ? meta_in.conf : meta_in.conf - 2'd1;
    end
    if (hit) begin
      trained = (ru[way] == 2'd3) ? ru[way] : ru[way] + 2'd1;
    end else begin
      trained = (ru[way] == 2'd0) ? ru[way] : ru[way] - 2'd1;
    end
    sel_n = sel_in;
    if (!hit && meta_in.kind == rdb_pkg::KIND_SRRIP && sel_in != SEL_MAX) begin
      sel_n = sel_in + 1'b1;
    end else if (!hit && meta_in.kind == rdb_pkg::KIND_BRRIP && sel_in != '0) begin
      sel_n = sel_in - 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_WAYS; i++) begin
      rr_new[i] = rr[i];
      ru_new[i] = ru[i];
    end
    meta_out = meta_in;
    sel_out = sel_in;
    vic_way = '0;
    reason = rdb_pkg::RSN_RRIP;
    rnd_used = 1'b0;
    ins = rdb_pkg::RRPV_MAX;
    if (op == rdb_pkg::OP_VICTIM) begin
      if (has_inv) begin
        vic_way = first_inv;
        reason = rdb_pkg::RSN_INVALID;
      end else if (meta_in.conf == rdb_pkg::CONF_MAX) begin
        if (has_r3) begin
          vic_way = first_r3;
          reason = rdb_pkg::RSN_STREAM_RRPV3;
        end else begin
          vic_way = rnd_way;
          reason = rdb_pkg::RSN_STREAM_RAND;
          rnd_used = 1'b1;
        end
      end else if (has_dead) begin
        vic_way = first_dead;
        reason = rdb_pkg::RSN_DEAD;
      end else begin
        // age the whole set so the oldest way reaches distant
        vic_way = first_mx;
        reason = rdb_pkg::RSN_RRIP;
        for (int i = 0; i < NUM_WAYS; i++) begin
          rr_new[i] = rr[i] + age_add;
        end
      end
    end else begin
      reason = rdb_pkg::RSN_UPDATE;
      meta_out.conf = conf_n;
      meta_out.prev_addr = addr_low;
      sel_out = sel_n;
      if (conf_n == rdb_pkg::CONF_MAX || trained == 2'd0) begin
        ins = rdb_pkg::RRPV_MAX;
      end else if (meta_in.kind == rdb_pkg::KIND_SRRIP) begin
        ins = rdb_pkg::RRPV_NEAR;
      end else if (meta_in.kind == rdb_pkg::KIND_BRRIP) begin
        ins = bim;
        rnd_used = 1'b1;
      end else if (sel_n >= SEL_HALF) begin
        ins = rdb_pkg::RRPV_NEAR;
      end else begin
        ins = bim;
        rnd_used = 1'b1;
      end
      rr_new[way] = ins;
      ru_new[way] = hit ? rdb_pkg::REUSE_HIT : rdb_pkg::REUSE_RST;
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      rrpv_out[2*i +: 2] = rr_new[i];
      reuse_out[2*i +: 2] = ru_new[i];
    end
  end

endmodule

// ===== hdl/rrip_dead_block_replacement.sv =====
// top level of the rrip dead block replacement policy: control, registers, row memory
// depends on rdb_pkg, rdb_row_mem, rdb_kernel
//
// Replacement policy engine for a set-associative cache. Each set lives in one
// row of a simple dual-port memory (per-way 2-bit rrpv and reuse counters, the
// stride detector and the set's dueling role); each request reads the row,
// works on it and writes it back. A request passes through accept, index
// reduction, row read, and execute and write. When NUM_SETS is below 2048 (or
// NUM_WAYS below 16) the reduction stage repeats, subtracting the set or way
// count until the index is in range. A victim request that completes a decay
// period first sweeps the whole memory, lowering every reuse counter. After
// reset a fill pass writes the reset row and the leader role into every set;
// no request is taken until it ends, while configuration writes are taken at
// any time. Requests run one at a time; the result sits in an output register
// so the next request is taken while it waits.
module rrip_dead_block_replacement #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16,
  parameter int LEADER_COUNT = 64,
  parameter int SELECTOR_BITS = 10
) (
  input  logic        clk,
  input  logic        rst,
  // request side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // set_index[10:0] way[14:11] valid_mask[30:15]
                                // addr_low[46:31] hit[47]
  input  logic        s_tuser,  // op
  // result side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // victim_way[3:0], zero fill[7:4]
  output logic [2:0]  m_tuser,  // victim_reason
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int SW = $clog2(NUM_SETS);
  localparam int WAY_W = $clog2(NUM_WAYS);
  localparam int RV_W = NUM_WAYS * 2;
  localparam int META_W = $bits(rdb_pkg::set_meta_t);
  localparam int ROW_W = RV_W * 2 + META_W;
  localparam int RS_W = (SW > 11) ? SW : 11;
  localparam int NUM_W = $clog2(LEADER_COUNT * NUM_SETS) + 2;
  localparam int LDR_W = $clog2(LEADER_COUNT + 1);
  localparam logic [SELECTOR_BITS-1:0] SEL_HALF = SELECTOR_BITS'(1) << (SELECTOR_BITS - 1);
  // reciprocal of the way count, exact for 16-bit dividends
  localparam logic [32:0] RECIP =
    33'(((64'd1 << 32) + 64'(NUM_WAYS) - 64'd1) / 64'(NUM_WAYS));

  rdb_pkg::state_t state, state_next;

  // configuration registers
  logic [19:0] decay_period;
  logic [15:0] stream_stride;
  logic [3:0]  bim_log2;

  // global state
  logic [SELECTOR_BITS-1:0] selector;
  logic [19:0] decay_count;
  logic [15:0] lfsr;
  logic        decay_pend;

  // latched request
  logic        req_op;
  logic        req_hit;
  logic [15:0] req_mask;
  logic [15:0] req_addr;
  logic [RS_W-1:0] red_set;
  logic [4:0]  red_way;

  // fill pass and decay sweep
  logic [SW-1:0]    sweep_row;
  logic [LDR_W-1:0] ldr;
  logic [NUM_W-1:0] ldr_num;
  logic [NUM_W-1:0] row_num;

  // random way
  logic [15:0] lfsr_nx;
  logic [48:0] rand_prod;
  logic [15:0] rand_q;
  logic [15:0] rand_rem;
  logic [WAY_W-1:0] rand_way;

  // output register
  logic       out_valid;
  logic [3:0] out_way;
  logic [2:0] out_reason;

  // memory controls
  logic             mem_we, mem_re;
  logic [SW-1:0]    mem_waddr, mem_raddr;
  logic [ROW_W-1:0] mem_wdata, mem_rdata;

  // kernel results
  logic [RV_W-1:0] k_rrpv, k_reuse;
  rdb_pkg::set_meta_t k_meta, row_meta, fill_meta;
  logic [SELECTOR_BITS-1:0] k_sel;
  logic [WAY_W-1:0] k_way;
  logic [2:0] k_reason;
  logic k_rnd_used;
  logic [WAY_W+3:0] k_way_ext;

  logic in_fire, ex_fire, set_big, way_big, red_done, fill_done;
  logic ldr_live, ldr_behind, ldr_here, fill_write;
  logic [19:0] count_inc;
  logic [RV_W-1:0] rrpv_fill, reuse_fill, reuse_decayed;

  assign s_tready  = (state == rdb_pkg::ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {4'd0, out_way};
  assign m_tuser   = out_reason;

  assign ex_fire   = (state == rdb_pkg::ST_EX) && (!out_valid || m_tready);
  assign count_inc = decay_count + 20'd1;

  // index reduction by repeated subtraction
  assign set_big  = {1'b0, red_set} >= (RS_W + 1)'(NUM_SETS);
  assign way_big  = {1'b0, red_way} >= 6'(NUM_WAYS);
  assign red_done = !set_big && !way_big;

  // leader map during fill: leader i sits at floor(i*NUM_SETS/LEADER_COUNT)
  assign ldr_live   = ldr < LDR_W'(LEADER_COUNT);
  assign ldr_behind = ldr_live && (ldr_num < row_num);
  assign ldr_here   = ldr_live && (ldr_num < row_num + NUM_W'(LEADER_COUNT));
  assign fill_write = (state == rdb_pkg::ST_CLEAR) && !ldr_behind;
  assign fill_done  = fill_write && (sweep_row == SW'(NUM_SETS - 1));

  assign lfsr_nx   = rdb_pkg::lfsr_step(lfsr);
  assign rand_prod = 49'(lfsr_nx) * 49'(RECIP);
  assign rand_rem  = lfsr_nx - 16'(32'(rand_q) * 32'(NUM_WAYS));
  assign rand_way  = WAY_W'((rand_rem >= 16'(NUM_WAYS)) ? rand_rem - 16'(NUM_WAYS) : rand_rem);

  always_comb begin
    fill_meta.prev_addr = 16'd0;
    fill_meta.conf = 2'd0;
    if (ldr_here) begin
      fill_meta.kind = (ldr < LDR_W'(LEADER_COUNT / 2)) ? rdb_pkg::KIND_SRRIP
                                                        : rdb_pkg::KIND_BRRIP;
    end else begin
      fill_meta.kind = rdb_pkg::KIND_FOLLOWER;
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      rrpv_fill[2*i +: 2] = rdb_pkg::RRPV_LONG;
      reuse_fill[2*i +: 2] = rdb_pkg::REUSE_RST;
      reuse_decayed[2*i +: 2] = (mem_rdata[RV_W + 2*i +: 2] == 2'd0)
                              ? 2'd0 : mem_rdata[RV_W + 2*i +: 2] - 2'd1;
    end
  end

  assign row_meta = mem_rdata[ROW_W-1 -: META_W];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rdb_pkg::ST_CLEAR: if (fill_done) state_next = rdb_pkg::ST_IDLE;
      rdb_pkg::ST_IDLE:  if (in_fire) state_next = rdb_pkg::ST_RED;
      rdb_pkg::ST_RED: begin
        if (red_done) state_next = decay_pend ? rdb_pkg::ST_DRD : rdb_pkg::ST_RD;
      end
      rdb_pkg::ST_DRD:   state_next = rdb_pkg::ST_DWR;
      rdb_pkg::ST_DWR: begin
        state_next = (sweep_row == SW'(NUM_SETS - 1)) ? rdb_pkg::ST_RD : rdb_pkg::ST_DRD;
      end
      rdb_pkg::ST_RD:    state_next = rdb_pkg::ST_EX;
      rdb_pkg::ST_EX:    if (ex_fire) state_next = rdb_pkg::ST_IDLE;
      default:           state_next = rdb_pkg::ST_CLEAR;
    endcase
  end

  // memory controls per state
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_waddr = sweep_row;
    mem_raddr = red_set[SW-1:0];
    mem_wdata = {fill_meta, reuse_fill, rrpv_fill};
    unique case (state)
      rdb_pkg::ST_CLEAR: mem_we = fill_write;
      rdb_pkg::ST_DRD: begin
        mem_re = 1'b1;
        mem_raddr = sweep_row;
      end
      rdb_pkg::ST_DWR: begin
        mem_we = 1'b1;
        mem_wdata = {mem_rdata[ROW_W-1 -: META_W], reuse_decayed, mem_rdata[RV_W-1:0]};
      end
      rdb_pkg::ST_RD:    mem_re = 1'b1;
      rdb_pkg::ST_EX: begin
        mem_we = ex_fire;
        mem_waddr = red_set[SW-1:0];
        mem_wdata = {k_meta, k_reuse, k_rrpv};
      end
      rdb_pkg::ST_IDLE, rdb_pkg::ST_RED: mem_we = 1'b0;
      default: mem_we = 1'b0;
    endcase
  end

  rdb_row_mem #(.DEPTH(NUM_SETS), .WIDTH(ROW_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rdb_kernel #(.NUM_WAYS(NUM_WAYS), .SELECTOR_BITS(SELECTOR_BITS)) u_kernel (
    .op         (req_op),
    .way        (red_way[WAY_W-1:0]),
    .valid_mask (req_mask),
    .addr_low   (req_addr),
    .hit        (req_hit),
    .rrpv_in    (mem_rdata[RV_W-1:0]),
    .reuse_in   (mem_rdata[2*RV_W-1:RV_W]),
    .meta_in    (row_meta),
    .sel_in     (selector),
    .stride     (stream_stride),
    .bim_log2   (bim_log2),
    .rnd        (lfsr_nx),
    .rnd_way    (rand_way),
    .rrpv_out   (k_rrpv),
    .reuse_out  (k_reuse),
    .meta_out   (k_meta),
    .sel_out    (k_sel),
    .vic_way    (k_way),
    .reason     (k_reason),
    .rnd_used   (k_rnd_used)
  );

  assign k_way_ext = (WAY_W + 4)'(k_way);

  // control and global registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdb_pkg::ST_CLEAR;
      decay_period <= rdb_pkg::DECAY_PERIOD_RST;
      stream_stride <= rdb_pkg::STREAM_STRIDE_RST;
      bim_log2 <= rdb_pkg::BIMODAL_LOG2_RST;
      selector <= SEL_HALF;
      decay_count <= 20'd0;
      lfsr <= rdb_pkg::LFSR_SEED;
      decay_pend <= 1'b0;
      sweep_row <= '0;
      ldr <= '0;
      ldr_num <= '0;
      row_num <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdb_pkg::CFG_DECAY_PERIOD:  decay_period <= cfg_data;
          rdb_pkg::CFG_STREAM_STRIDE: stream_stride <= cfg_data[15:0];
          rdb_pkg::CFG_BIMODAL_LOG2:  bim_log2 <= cfg_data[3:0];
          default: ;
        endcase
      end
      // fill pass: step the leader pointer or write one row
      if (state == rdb_pkg::ST_CLEAR) begin
        if (ldr_behind) begin
          ldr <= ldr + 1'b1;
          ldr_num <= ldr_num + NUM_W'(NUM_SETS);
        end else begin
          sweep_row <= sweep_row + 1'b1;
          row_num <= row_num + NUM_W'(LEADER_COUNT);
        end
      end
      if (in_fire) begin
        sweep_row <= '0;
        decay_pend <= 1'b0;
        if (s_tuser == rdb_pkg::OP_VICTIM) begin
          if (count_inc >= decay_period) begin
            decay_count <= 20'd0;
            decay_pend <= 1'b1;
          end else begin
            decay_count <= count_inc;
          end
        end
      end
      if (state == rdb_pkg::ST_DWR) begin
        sweep_row <= sweep_row + 1'b1;
      end
      if (ex_fire) begin
        selector <= k_sel;
        if (k_rnd_used) begin
          lfsr <= lfsr_nx;
        end
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request payload and index reduction
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_op <= s_tuser;
      req_hit <= s_tdata[47];
      req_mask <= s_tdata[30:15];
      req_addr <= s_tdata[46:31];
      red_set <= RS_W'(s_tdata[10:0]);
      red_way <= 5'(s_tdata[14:11]);
    end else if (state == rdb_pkg::ST_RED) begin
      if (set_big) begin
        red_set <= red_set - RS_W'(NUM_SETS);
      end
      if (way_big) begin
        red_way <= red_way - 5'(NUM_WAYS);
      end
    end
    if (state == rdb_pkg::ST_RD) begin
      rand_q <= rand_prod[47:32];
    end
    if (ex_fire) begin
      out_way <= k_way_ext[3:0];
      out_reason <= k_reason;
    end
  end

endmodule

// ===== hdl/rdb_checker.sv =====
// port-level checks for the rrip dead block replacement block, bound to the top level
// depends on rdb_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic [2:0]  m_tuser
);

  // reason codes stay within the defined set
  `ASSERT_SAME(a_reason_range, clk, rst, m_tvalid, m_tuser <= rdb_pkg::RSN_UPDATE)
  // an update request reports way zero
  `ASSERT_SAME(a_update_way, clk, rst, m_tvalid && m_tuser == rdb_pkg::RSN_UPDATE, m_tdata == 8'd0)
  // one request at a time: busy right after a request is taken
  `ASSERT_NEXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready)
  // a stalled result holds
  `ASSERT_NEXT(a_result_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind rrip_dead_block_replacement rdb_checker u_rdb_checker (.*);
